/* rtl/core/pixel_difference_mse_macros.svh */
// Assertion macros for the pixel difference / MSE core.
// No dependencies; included by modules that carry assertions.
`ifndef PIXEL_DIFFERENCE_MSE_MACROS_SVH
`define PIXEL_DIFFERENCE_MSE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define PDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define PDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pdm_pkg.sv */
// Shared constants and types for the pixel difference / MSE core.
// No dependencies.
package pdm_pkg;

    parameter int PIX_W      = 8;
    parameter int COUNT_BITS = 24;
    parameter int CNT_W      = COUNT_BITS + 1;
    parameter int ACC_W      = 40;
    parameter int FRAC_BITS  = 8;
    parameter int DVD_W      = ACC_W + FRAC_BITS;
    parameter int MSE_W      = 24;
    parameter int TOTAL_W    = 26;
    parameter int DIV_STEPS  = DVD_W;
    parameter int STEP_W     = $clog2(DIV_STEPS);
    parameter int S_DATA_W   = 6 * PIX_W;
    parameter int M_DATA_W   = 128;

    parameter logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1) << COUNT_BITS;
    parameter logic [PIX_W:0]   DIFF_BIAS = (PIX_W+1)'(128);
    parameter logic [PIX_W-1:0] PIX_MAX   = PIX_W'(255);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_FIN
    } pdm_state_t;

    typedef struct packed {
        logic acc_en;
        logic acc_clr;
        logic div_start;
        logic div_step;
    } pdm_lane_ctrl_t;

endpackage

/* rtl/core/pdm_lane.sv */
// One colour channel: clipped difference, squared-error accumulator and
// a radix-2 restoring divider for the frame MSE. Depends on pdm_pkg.
module pdm_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pdm_pkg::pdm_lane_ctrl_t       ctrl,
    input  logic [pdm_pkg::PIX_W-1:0]     pix_a,
    input  logic [pdm_pkg::PIX_W-1:0]     pix_b,
    input  logic [pdm_pkg::CNT_W-1:0]     divisor,
    output logic [pdm_pkg::PIX_W-1:0]     diff,
    output logic [pdm_pkg::MSE_W-1:0]     mse
);

    logic [pdm_pkg::ACC_W-1:0]     acc_reg, acc_next, acc_sum_sat;
    logic [pdm_pkg::ACC_W:0]       acc_sum;
    logic [pdm_pkg::PIX_W:0]       biased, shifted;
    logic [pdm_pkg::PIX_W-1:0]     abs_d;
    logic [2*pdm_pkg::PIX_W-1:0]   sq;
    logic [pdm_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [pdm_pkg::CNT_W:0]       trial;
    logic [pdm_pkg::DVD_W-1:0]     quo_reg, quo_next;
    logic                          q_bit;

    // 128 + a - b, clipped
    always_comb begin
        biased  = {1'b0, pix_a} + pdm_pkg::DIFF_BIAS;
        shifted = biased - {1'b0, pix_b};
        if (biased < {1'b0, pix_b}) begin
            diff = '0;
        end else if (shifted[pdm_pkg::PIX_W]) begin
            diff = pdm_pkg::PIX_MAX;
        end else begin
            diff = shifted[pdm_pkg::PIX_W-1:0];
        end
    end

    always_comb begin
        abs_d       = (pix_a >= pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
        sq          = abs_d * abs_d;
        acc_sum     = {1'b0, acc_reg} + {{(pdm_pkg::ACC_W + 1 - 2*pdm_pkg::PIX_W){1'b0}}, sq};
        acc_sum_sat = acc_sum[pdm_pkg::ACC_W] ? {pdm_pkg::ACC_W{1'b1}}
                                              : acc_sum[pdm_pkg::ACC_W-1:0];
        acc_next    = ctrl.acc_en ? acc_sum_sat : acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // one quotient bit per step, dividend = sse << FRAC_BITS
    always_comb begin
        trial    = {rem_reg, quo_reg[pdm_pkg::DVD_W-1]};
        q_bit    = (trial >= {1'b0, divisor});
        rem_next = q_bit ? pdm_pkg::CNT_W'(trial - {1'b0, divisor})
                         : trial[pdm_pkg::CNT_W-1:0];
        quo_next = {quo_reg[pdm_pkg::DVD_W-2:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.div_start) begin
            rem_reg <= '0;
            quo_reg <= {acc_next, {pdm_pkg::FRAC_BITS{1'b0}}};
        end else if (ctrl.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign mse = (|quo_reg[pdm_pkg::DVD_W-1:pdm_pkg::MSE_W]) ? {pdm_pkg::MSE_W{1'b1}}
                                                              : quo_reg[pdm_pkg::MSE_W-1:0];

endmodule

/* rtl/core/pdm_merge.sv */
// Merges the three lanes: MSE total and packing of the result word.
// Depends on pdm_pkg.
module pdm_merge (
    input  logic                            stats,
    input  logic [pdm_pkg::PIX_W-1:0]       diff_red,
    input  logic [pdm_pkg::PIX_W-1:0]       diff_green,
    input  logic [pdm_pkg::PIX_W-1:0]       diff_blue,
    input  logic [pdm_pkg::MSE_W-1:0]       mse_red,
    input  logic [pdm_pkg::MSE_W-1:0]       mse_green,
    input  logic [pdm_pkg::MSE_W-1:0]       mse_blue,
    output logic [pdm_pkg::M_DATA_W-1:0]    data
);

    logic [pdm_pkg::MSE_W-1:0]   r, g, b;
    logic [pdm_pkg::TOTAL_W-1:0] total;

    always_comb begin
        r     = stats ? mse_red   : '0;
        g     = stats ? mse_green : '0;
        b     = stats ? mse_blue  : '0;
        total = pdm_pkg::TOTAL_W'(r) + pdm_pkg::TOTAL_W'(g) + pdm_pkg::TOTAL_W'(b);
        data  = pdm_pkg::M_DATA_W'({total, b, g, r, diff_blue, diff_green, diff_red});
    end

endmodule

/* rtl/core/pixel_difference_mse.sv */
// Pixel difference / MSE core: a non-last pixel gives a registered result in the cycle
// after it is accepted; one pixel per cycle while the frame runs and the output is not
// stalled. A last pixel starts a 48-step bit-serial division in each of the three lanes,
// side by side; input is held off until its result is loaded for output. Synchronous
// active-low reset clears accumulators, pixel count, state and the output valid.
// Depends on pdm_pkg, pdm_lane, pdm_merge and pixel_difference_mse_macros.svh.
`include "pixel_difference_mse_macros.svh"

module pixel_difference_mse (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_red, a_green, a_blue, b_red, b_green, b_blue
    input  logic [pdm_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // diff_red, diff_green, diff_blue, mse_red, mse_green, mse_blue, mse_total, zero pad
    output logic [pdm_pkg::M_DATA_W-1:0]    m_tdata,
    // stats_valid
    output logic                            m_tuser
);

    localparam int PW = pdm_pkg::PIX_W;

    pdm_pkg::pdm_state_t           state_reg, state_next;
    pdm_pkg::pdm_lane_ctrl_t       ctrl;
    logic [pdm_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [pdm_pkg::CNT_W-1:0]     count_reg, count_next, count_inc;
    logic [pdm_pkg::CNT_W-1:0]     divisor_reg;
    logic [3*PW-1:0]               diff_hold_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [pdm_pkg::M_DATA_W-1:0]  out_data_reg, merged;
    logic                          out_user_reg;
    logic                          accept, out_free, div_done, fin_load, out_load;
    logic [PW-1:0]                 d_red, d_green, d_blue;
    logic [PW-1:0]                 m_red, m_green, m_blue;
    logic [pdm_pkg::MSE_W-1:0]     mse_red, mse_green, mse_blue;

    pdm_lane u_lane_red (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
        .pix_a(s_tdata[PW-1:0]), .pix_b(s_tdata[4*PW-1:3*PW]),
        .divisor(divisor_reg), .diff(d_red), .mse(mse_red)
    );

    pdm_lane u_lane_green (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
        .pix_a(s_tdata[2*PW-1:PW]), .pix_b(s_tdata[5*PW-1:4*PW]),
        .divisor(divisor_reg), .diff(d_green), .mse(mse_green)
    );

    pdm_lane u_lane_blue (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
        .pix_a(s_tdata[3*PW-1:2*PW]), .pix_b(s_tdata[6*PW-1:5*PW]),
        .divisor(divisor_reg), .diff(d_blue), .mse(mse_blue)
    );

    assign m_red   = fin_load ? diff_hold_reg[PW-1:0]      : d_red;
    assign m_green = fin_load ? diff_hold_reg[2*PW-1:PW]   : d_green;
    assign m_blue  = fin_load ? diff_hold_reg[3*PW-1:2*PW] : d_blue;

    pdm_merge u_merge (
        .stats(fin_load),
        .diff_red(m_red), .diff_green(m_green), .diff_blue(m_blue),
        .mse_red(mse_red), .mse_green(mse_green), .mse_blue(mse_blue),
        .data(merged)
    );

    // outputs of the sequencer
    always_comb begin
        out_free       = !out_valid_reg || m_tready;
        s_tready       = (state_reg == pdm_pkg::ST_RUN) && out_free;
        accept         = s_tvalid && s_tready;
        div_done       = (state_reg == pdm_pkg::ST_DIV) &&
                         (step_reg == pdm_pkg::STEP_W'(pdm_pkg::DIV_STEPS - 1));
        fin_load       = (state_reg == pdm_pkg::ST_FIN) && out_free;
        out_load       = (accept && !s_tlast) || fin_load;
        ctrl.acc_en    = accept;
        ctrl.acc_clr   = accept && s_tlast;
        ctrl.div_start = accept && s_tlast;
        ctrl.div_step  = (state_reg == pdm_pkg::ST_DIV);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pdm_pkg::ST_RUN: begin
                if (accept && s_tlast) begin
                    state_next = pdm_pkg::ST_DIV;
                end
            end
            pdm_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = pdm_pkg::ST_FIN;
                end
            end
            pdm_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = pdm_pkg::ST_RUN;
                end
            end
            default: state_next = pdm_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        count_inc  = (count_reg < pdm_pkg::COUNT_MAX) ? count_reg + pdm_pkg::CNT_W'(1)
                                                      : count_reg;
        count_next = count_reg;
        if (accept) begin
            count_next = s_tlast ? '0 : count_inc;
        end
        step_next = '0;
        if (state_reg == pdm_pkg::ST_DIV) begin
            step_next = step_reg + pdm_pkg::STEP_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pdm_pkg::ST_RUN;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            divisor_reg   <= count_inc;
            diff_hold_reg <= {d_blue, d_green, d_red};
        end
        if (out_load) begin
            out_data_reg <= merged;
            out_user_reg <= fin_load;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `PDM_ASSERT_NEXT(a_last_holds_input, accept && s_tlast, !s_tready,
        "input taken during frame-end division")
    `PDM_ASSERT_NEXT(a_div_to_fin, div_done, state_reg == pdm_pkg::ST_FIN,
        "division did not finish after its last step")
    `PDM_ASSERT_NEXT(a_fin_emits_stats, fin_load, m_tvalid && m_tuser,
        "frame statistics not presented")
    `PDM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= pdm_pkg::COUNT_MAX,
        "pixel count beyond saturation")

endmodule

/* tb/tb.sv */
// Self-checking testbench for pixel_difference_mse: difference pixels and per-frame MSE.
// A scoreboard class predicts every result transfer from the accepted pixel pairs.
// Depends on pdm_pkg and the pixel_difference_mse RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W     = pdm_pkg::PIX_W;
    localparam int M_DATA_W  = pdm_pkg::M_DATA_W;
    localparam int S_DATA_W  = pdm_pkg::S_DATA_W;
    localparam int MSE_W     = pdm_pkg::MSE_W;
    localparam int TOTAL_W   = pdm_pkg::TOTAL_W;
    localparam int ACC_W     = pdm_pkg::ACC_W;
    localparam int CNT_W     = pdm_pkg::CNT_W;
    localparam int FRAC_BITS = pdm_pkg::FRAC_BITS;
    localparam logic [CNT_W-1:0] COUNT_MAX = pdm_pkg::COUNT_MAX;

    localparam int PAD_W = M_DATA_W - 3 * PIX_W - 3 * MSE_W - TOTAL_W;
    localparam longint unsigned SSE_LIMIT = (64'd1 << ACC_W) - 1;
    localparam longint unsigned MSE_LIMIT = (64'd1 << MSE_W) - 1;
    localparam int PIXELS_WANTED = 1600;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [PIX_W-1:0] b_blue;
        logic [PIX_W-1:0] b_green;
        logic [PIX_W-1:0] b_red;
        logic [PIX_W-1:0] a_blue;
        logic [PIX_W-1:0] a_green;
        logic [PIX_W-1:0] a_red;
    } pixel_pair_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        logic [TOTAL_W-1:0] mse_total;
        logic [MSE_W-1:0]   mse_blue;
        logic [MSE_W-1:0]   mse_green;
        logic [MSE_W-1:0]   mse_red;
        logic [PIX_W-1:0]   diff_blue;
        logic [PIX_W-1:0]   diff_green;
        logic [PIX_W-1:0]   diff_red;
    } result_fields_t;

    typedef struct packed {
        logic           stats_valid;
        result_fields_t fields;
    } pixel_result_t;

    class frame_error_scoreboard;
        logic [ACC_W-1:0] sse [3];
        logic [CNT_W-1:0] frame_pixels;
        pixel_result_t    pending_results [$];
        int               mismatches;

        function new();
            clear_frame();
            mismatches = 0;
        endfunction

        function void clear_frame();
            for (int c = 0; c < 3; c++) sse[c] = '0;
            frame_pixels = '0;
        endfunction

        function void add_pixel(pixel_pair_t px, logic last);
            logic [PIX_W-1:0] a [3];
            logic [PIX_W-1:0] b [3];
            logic [PIX_W-1:0] diff [3];
            logic [MSE_W-1:0] mse [3];
            int               v;
            longint unsigned  d;
            longint unsigned  s;
            pixel_result_t    r;
            a = '{px.a_red, px.a_green, px.a_blue};
            b = '{px.b_red, px.b_green, px.b_blue};
            r = '0;
            if (frame_pixels < COUNT_MAX) frame_pixels++;
            for (int c = 0; c < 3; c++) begin
                v = 128 + int'(a[c]) - int'(b[c]);
                if (v < 0) v = 0;
                else if (v > 255) v = 255;
                diff[c] = PIX_W'(v);
                d = (a[c] >= b[c]) ? longint'(a[c] - b[c]) : longint'(b[c] - a[c]);
                s = longint'(sse[c]) + d * d;
                sse[c] = ACC_W'((s > SSE_LIMIT) ? SSE_LIMIT : s);
                s = (longint'(sse[c]) << FRAC_BITS) / longint'(frame_pixels);
                mse[c] = MSE_W'((s > MSE_LIMIT) ? MSE_LIMIT : s);
            end
            r.fields.diff_red   = diff[0];
            r.fields.diff_green = diff[1];
            r.fields.diff_blue  = diff[2];
            if (last) begin
                r.stats_valid      = 1'b1;
                r.fields.mse_red   = mse[0];
                r.fields.mse_green = mse[1];
                r.fields.mse_blue  = mse[2];
                r.fields.mse_total = TOTAL_W'(mse[0]) + TOTAL_W'(mse[1]) + TOTAL_W'(mse[2]);
                clear_frame();
            end
            pending_results.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic user);
            pixel_result_t  want;
            result_fields_t got;
            if (pending_results.size() == 0) begin
                $error("result transfer with no pixel pair outstanding");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            got = data;
            compare("diff_red", want.fields.diff_red, got.diff_red);
            compare("diff_green", want.fields.diff_green, got.diff_green);
            compare("diff_blue", want.fields.diff_blue, got.diff_blue);
            compare("stats_valid", want.stats_valid, user);
            compare("mse_red", want.fields.mse_red, got.mse_red);
            compare("mse_green", want.fields.mse_green, got.mse_green);
            compare("mse_blue", want.fields.mse_blue, got.mse_blue);
            compare("mse_total", want.fields.mse_total, got.mse_total);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;   // a_red, a_green, a_blue, b_red, b_green, b_blue
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // diff r/g/b, mse r/g/b, mse_total, pad
    logic                  m_tuser;         // stats_valid

    frame_error_scoreboard sb = new();
    int                    burst_left = 0;

    pixel_difference_mse dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #8ms;
        $display("Mismatches found");
        $finish;
    end

    // receiver back-pressure: modes of random length
    initial begin : ready_pattern
        int left;
        int mode;
        int tick;
        left = 0;
        mode = 0;
        tick = 0;
        forever begin
            @(posedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 200);
            end
            left--;
            tick++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ((tick % 7) < 4);
                default: m_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    task automatic send_pixel(pixel_pair_t px, logic last);
        int   gap;
        logic took;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        sb.add_pixel(px, last);
    endtask

    function automatic pixel_pair_t make_pair(int ar, int ag, int ab, int br, int bg, int bb);
        return '{a_red: PIX_W'(ar), a_green: PIX_W'(ag), a_blue: PIX_W'(ab),
                 b_red: PIX_W'(br), b_green: PIX_W'(bg), b_blue: PIX_W'(bb)};
    endfunction

    // style 0 uniform, 1 near-equal, 2 extremes and clip edges, 3 mixed per channel
    function automatic pixel_pair_t random_pixel(int style);
        int a [3];
        int b [3];
        int kind;
        for (int c = 0; c < 3; c++) begin
            kind = (style == 3) ? $urandom_range(0, 2) : style;
            a[c] = $urandom_range(0, 255);
            case (kind)
                0: b[c] = $urandom_range(0, 255);
                1: b[c] = a[c] + $urandom_range(0, 16) - 8;
                default: begin
                    case ($urandom_range(0, 2))
                        0: begin
                            a[c] = $urandom_range(0, 1) * 255;
                            b[c] = $urandom_range(0, 1) * 255;
                        end
                        1: b[c] = a[c] - 128 + $urandom_range(0, 2) - 1;
                        default: b[c] = a[c] + 128 + $urandom_range(0, 2) - 1;
                    endcase
                end
            endcase
            if (b[c] < 0) b[c] = 0;
            if (b[c] > 255) b[c] = 255;
        end
        return make_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
    endfunction

    initial begin : stimulus
        int sent;
        int len;
        int style;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-pixel frames straight after reset: clip both ways, largest errors
        send_pixel(make_pair(255, 0, 128, 0, 255, 128), 1'b1);
        send_pixel(make_pair(255, 255, 255, 0, 0, 0), 1'b1);
        // edges of the clipping window
        send_pixel(make_pair(127, 0, 200, 0, 128, 72), 1'b0);
        send_pixel(make_pair(0, 129, 72, 127, 0, 201), 1'b0);
        send_pixel(make_pair(8'hAA, 8'h55, 8'hFF, 8'h55, 8'hAA, 8'h00), 1'b1);
        // zero-error frame
        send_pixel(make_pair(0, 0, 0, 0, 0, 0), 1'b0);
        send_pixel(make_pair(200, 17, 90, 200, 17, 90), 1'b0);
        send_pixel(make_pair(255, 255, 255, 255, 255, 255), 1'b1);
        // quotients that truncate
        send_pixel(make_pair(10, 20, 30, 13, 21, 25), 1'b0);
        send_pixel(make_pair(1, 2, 3, 2, 2, 4), 1'b0);
        send_pixel(make_pair(100, 50, 7, 99, 57, 0), 1'b0);
        send_pixel(make_pair(0, 0, 1, 1, 0, 0), 1'b0);
        send_pixel(make_pair(5, 6, 7, 6, 6, 7), 1'b0);
        send_pixel(make_pair(9, 9, 9, 9, 9, 8), 1'b0);
        send_pixel(make_pair(40, 41, 42, 43, 44, 45), 1'b1);
        send_pixel(make_pair(0, 255, 1, 1, 254, 0), 1'b1);

        sent = 0;
        while (sent < PIXELS_WANTED) begin
            case ($urandom_range(0, 9))
                0: len = 1;
                1: len = $urandom_range(60, 250);
                default: len = $urandom_range(2, 24);
            endcase
            style = $urandom_range(0, 3);
            for (int i = 0; i < len; i++)
                send_pixel(random_pixel(style), i == len - 1);
            sent += len;
        end
        s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pdm_pkg.sv
rtl/core/pdm_lane.sv
rtl/core/pdm_merge.sv
rtl/core/pixel_difference_mse.sv
tb/tb.sv
